### hw/rtl/swb_pkg.sv
// shared types and constants of the sliding window bitmap unit
// no dependencies; used by swb_queue, swb_engine and the top level of the block

package swb_pkg;

  localparam int BLOCK_BYTES_DEF = 32;
  localparam int NUM_BLOCKS_DEF  = 8;

  // depth of the command queue between intake and engine
  localparam int QUEUE_DEPTH = 2;

  localparam int POS_W = 32;

  typedef enum logic [1:0] {
    STAT_NEW    = 2'd0,
    STAT_DUP    = 2'd1,
    STAT_BELOW  = 2'd2,
    STAT_BEYOND = 2'd3
  } status_e;

  typedef struct packed {
    logic             avail;
    logic [POS_W-1:0] position;
  } qhead_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [POS_W-1:0] window_bottom;
  } result_t;

endpackage

### hw/rtl/swb_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies

module swb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/swb_queue.sv
// front part: command intake queue holding positions until the engine takes them
// depends on swb_pkg

module swb_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [swb_pkg::POS_W-1:0]  data_i,
  output logic                       full_o,
  output logic                       empty_o,
  output swb_pkg::qhead_t            head_o,
  input  logic                       pop_i
);

  localparam int DEPTH = swb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [swb_pkg::POS_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]          wptr_q, rptr_q;
  logic [CNT_W-1:0]          count_q;
  logic                      do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  assign head_o.avail    = !empty_o;
  assign head_o.position = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/swb_engine.sv
// back part: classifies a position against the window, read-modify-writes its
// block and slides the window; depends on swb_pkg and swb_ram

module swb_engine #(
  parameter int BLOCK_BYTES = swb_pkg::BLOCK_BYTES_DEF,
  parameter int NUM_BLOCKS  = swb_pkg::NUM_BLOCKS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swb_pkg::POS_W-1:0] cfg_base_i,
  input  swb_pkg::qhead_t           head_i,
  output logic                      pop_o,
  output logic                      idle_o,
  output swb_pkg::result_t          res_o
);

  localparam int BLOCK_BITS = BLOCK_BYTES * 8;
  localparam int CAPACITY   = NUM_BLOCKS * BLOCK_BITS;
  localparam int OFF_W      = $clog2(CAPACITY);
  localparam int BIT_W      = $clog2(BLOCK_BITS);
  localparam int SLOT_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int PW         = swb_pkg::POS_W;
  localparam logic [PW-1:0] CAP_W  = PW'(CAPACITY);
  localparam logic [PW-1:0] STEP_W = PW'(BLOCK_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_UPDATE,
    ST_SLIDE
  } state_e;

  state_e                state_q;
  logic [PW-1:0]         window_low_q;
  logic [SLOT_W-1:0]     bottom_q;
  logic [NUM_BLOCKS-1:0] valid_q;
  logic [NUM_BLOCKS-1:0] full_q;
  logic [OFF_W-1:0]      off_q;
  logic [BIT_W-1:0]      bit_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  valid_rd_q;
  swb_pkg::result_t      res_q;

  // classification of the queue head
  logic          below;
  logic          beyond;
  logic [PW-1:0] diff;

  assign below  = head_i.position < window_low_q;
  assign diff   = head_i.position - window_low_q;
  assign beyond = diff >= CAP_W;

  // block index and bit index from the offset; one range compare per block
  logic [SLOT_W-1:0] blk;
  logic [OFF_W-1:0]  blk_base;
  logic [OFF_W-1:0]  bit_full;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_d;

  always_comb begin
    blk      = '0;
    blk_base = '0;
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      if ({1'b0, off_q} >= (OFF_W + 1)'(k * BLOCK_BITS) &&
          {1'b0, off_q} <  (OFF_W + 1)'((k + 1) * BLOCK_BITS)) begin
        blk      = blk | SLOT_W'(k);
        blk_base = blk_base | OFF_W'(k * BLOCK_BITS);
      end
    end
  end

  assign bit_full = off_q - blk_base;
  assign slot_sum = {1'b0, bottom_q} + {1'b0, blk};
  assign slot_d   = (slot_sum >= (SLOT_W + 1)'(NUM_BLOCKS))
                  ? SLOT_W'(slot_sum - (SLOT_W + 1)'(NUM_BLOCKS))
                  : slot_sum[SLOT_W-1:0];

  // block storage
  logic [BLOCK_BITS-1:0] rdata;
  logic [BLOCK_BITS-1:0] old_bits;
  logic [BLOCK_BITS-1:0] new_bits;
  logic                  hit;
  logic                  ram_we;
  logic                  ram_re;
  logic                  bottom_fills;

  assign old_bits     = valid_rd_q ? rdata : '0;
  assign hit          = old_bits[bit_q];
  assign new_bits     = old_bits | (BLOCK_BITS'(1) << bit_q);
  assign ram_we       = (state_q == ST_UPDATE) && !hit;
  assign ram_re       = (state_q == ST_LOCATE);
  assign bottom_fills = (slot_q == bottom_q) && (&new_bits);

  swb_ram #(
    .WIDTH (BLOCK_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (new_bits),
    .re_i    (ram_re),
    .raddr_i (slot_d),
    .rdata_o (rdata)
  );

  assign idle_o = (state_q == ST_IDLE);
  assign pop_o  = (state_q == ST_IDLE) && head_i.avail;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      window_low_q  <= '0;
      bottom_q      <= '0;
      valid_q       <= '0;
      full_q        <= '0;
      off_q         <= '0;
      bit_q         <= '0;
      slot_q        <= '0;
      valid_rd_q    <= 1'b0;
      res_q         <= '0;
    end else begin
      res_q.valid <= 1'b0;
      if (cfg_we_i) begin
        window_low_q <= cfg_base_i;
        bottom_q     <= '0;
        valid_q      <= '0;
        full_q       <= '0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (head_i.avail) begin
            off_q <= diff[OFF_W-1:0];
            if (below || beyond) begin
              res_q.valid         <= 1'b1;
              res_q.status        <= below ? swb_pkg::STAT_BELOW : swb_pkg::STAT_BEYOND;
              res_q.window_bottom <= window_low_q;
            end else begin
              state_q <= ST_LOCATE;
            end
          end
        end
        ST_LOCATE: begin
          bit_q      <= bit_full[BIT_W-1:0];
          slot_q     <= slot_d;
          valid_rd_q <= valid_q[slot_d];
          state_q    <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (!hit) begin
            valid_q[slot_q] <= 1'b1;
            full_q[slot_q]  <= &new_bits;
          end
          if (!hit && bottom_fills) begin
            state_q <= ST_SLIDE;
          end else begin
            res_q.valid         <= 1'b1;
            res_q.status        <= hit ? swb_pkg::STAT_DUP : swb_pkg::STAT_NEW;
            res_q.window_bottom <= window_low_q;
            state_q             <= ST_IDLE;
          end
        end
        ST_SLIDE: begin
          // one block per cycle while the bottom block stays full
          if (full_q[bottom_q]) begin
            valid_q[bottom_q] <= 1'b0;
            full_q[bottom_q]  <= 1'b0;
            bottom_q          <= (bottom_q == SLOT_W'(NUM_BLOCKS - 1))
                               ? '0 : bottom_q + SLOT_W'(1);
            window_low_q      <= window_low_q + STEP_W;
          end else begin
            res_q.valid         <= 1'b1;
            res_q.status        <= swb_pkg::STAT_NEW;
            res_q.window_bottom <= window_low_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sliding_window_bitmap_unit.sv
// top level of the sliding window bitmap unit
// depends on swb_pkg, swb_queue and swb_engine
//
// Marks absolute positions in a window of NUM_BLOCKS blocks of BLOCK_BYTES*8 bits.
// Command channel: a position is taken at a clock edge with start high and busy
// low. A two-entry queue feeds the engine, so busy rises only when it is full.
// Result channel: done_o is high for one cycle with status_o and window_bottom_o;
// the receiver cannot stall, so results never wait.
// A position below or beyond the window is answered from the idle state; an
// in-window mark passes through the locate and update states, and through
// the slide state when the window slides.
// Throughput: one out-of-window item per cycle while the engine is idle; an
// in-window item holds the engine through the read of its block in the ram and
// the write back, plus the slide steps, which advance the window one block each.
// Configuration: a write on cfg_valid_i/cfg_ready_o loads the window bottom and
// clears the map through per-block valid bits; cfg_ready_o is high only while
// the queue is empty and the engine idle.
// Reset clears the map at once, sets the window bottom to 0 and empties the queue.

module sliding_window_bitmap_unit #(
  parameter int BLOCK_BYTES = swb_pkg::BLOCK_BYTES_DEF,
  parameter int NUM_BLOCKS  = swb_pkg::NUM_BLOCKS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [swb_pkg::POS_W-1:0] position_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [swb_pkg::POS_W-1:0] window_bottom_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [swb_pkg::POS_W-1:0] cfg_window_base_i
);

  swb_pkg::qhead_t  head;
  swb_pkg::result_t res;
  logic             q_full, q_empty, pop, idle;

  swb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .data_i  (position_i),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head),
    .pop_i   (pop)
  );

  swb_engine #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_base_i (cfg_window_base_i),
    .head_i     (head),
    .pop_o      (pop),
    .idle_o     (idle),
    .res_o      (res)
  );

  assign busy            = q_full;
  assign cfg_ready_o     = idle && q_empty;
  assign done_o          = res.valid;
  assign status_o        = res.status;
  assign window_bottom_o = res.window_bottom;

endmodule

### hw/rtl/swb_checker.sv
// port-level checks of the sliding window bitmap unit, bound to the top level
// depends on sliding_window_bitmap_unit

module swb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  // a map reload happens with nothing in flight, so no result can follow it
  a_no_result_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !done_o)
    else $error("result right after a configuration transaction");

  // an accepted command keeps the block from taking configuration
  a_cmd_blocks_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !cfg_ready_o)
    else $error("configuration ready with a command in flight");

  // the queue only fills through an accepted command
  a_busy_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transaction");

endmodule

bind sliding_window_bitmap_unit swb_checker u_swb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
